### rtl/rme_pkg.sv
// Shared definitions for the modular exponentiation block.
// Configuration register indexes and their type; no dependencies.
package rme_pkg;

    localparam int CFG_INDEX_WIDTH = 1;

    typedef logic [CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t REG_EXPONENT = 1'b0;
    localparam cfg_index_t REG_MODULUS  = 1'b1;

endpackage

### rtl/rme_modmul.sv
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Computes a * b mod m for a < m, m >= 2; standalone, no package use.
module rme_modmul #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [WORD_WIDTH-1:0] a,
    input  logic [WORD_WIDTH-1:0] b,
    input  logic [WORD_WIDTH-1:0] m,
    output logic                  done,
    output logic [WORD_WIDTH-1:0] product
);

    localparam int CNT_W = $clog2(WORD_WIDTH);

    logic [WORD_WIDTH-1:0] a_reg;
    logic [WORD_WIDTH-1:0] m_reg;
    logic [WORD_WIDTH-1:0] b_sh_reg;
    logic [WORD_WIDTH-1:0] acc_reg;
    logic [WORD_WIDTH-1:0] acc_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  run_reg;
    logic                  done_reg;

    logic [WORD_WIDTH+1:0] sum;
    logic [WORD_WIDTH+2:0] diff1;
    logic [WORD_WIDTH+2:0] diff2;

    always_comb
    begin
        sum   = {1'b0, acc_reg, 1'b0}
              + {2'b00, a_reg & {WORD_WIDTH{b_sh_reg[WORD_WIDTH-1]}}};
        diff1 = {1'b0, sum} - {3'b000, m_reg};
        diff2 = {1'b0, sum} - {2'b00, m_reg, 1'b0};
        priority if (!diff2[WORD_WIDTH+2])
        begin
            acc_next = diff2[WORD_WIDTH-1:0];
        end
        else if (!diff1[WORD_WIDTH+2])
        begin
            acc_next = diff1[WORD_WIDTH-1:0];
        end
        else
        begin
            acc_next = sum[WORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(WORD_WIDTH - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            m_reg    <= m;
            b_sh_reg <= b;
            acc_reg  <= '0;
        end
        else if (run_reg)
        begin
            acc_reg  <= acc_next;
            b_sh_reg <= {b_sh_reg[WORD_WIDTH-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### rtl/rsa_modular_exponentiation.sv
// Top level of the modular exponentiation block: register file, sequencer, output register.
// Depends on rme_pkg and rme_modmul.
//
// Usage: write the exponent (index 0) and modulus (index 1) over the cfg channel
// while the block is idle; cfg_ready is always high. Each base_value transaction
// on the input channel returns one power_value = base^exponent mod modulus.
// A zero exponent returns 1; a modulus below 2 returns 0 otherwise.
// Every modular multiply runs through the bit-serial multiplier, one exponent
// bit per square step. A transaction reduces the base once, then runs a square
// step for every one of the WORD_WIDTH exponent bits, MSB first, and a multiply
// after each square on a set bit; special cases (zero exponent, modulus below 2)
// skip the multiplier.
// One transaction is processed at a time; in_ready is high only while the
// sequencer is idle.
// The result sits in an output register: the next transaction is accepted
// while it waits, and the block stalls at completion of that next one until
// the receiver takes the previous result.
// Reset: asynchronous, active low; exponent returns to 1, modulus to 2,
// no result pending.
module rsa_modular_exponentiation #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [WORD_WIDTH-1:0] base_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [WORD_WIDTH-1:0] power_value,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  rme_pkg::cfg_index_t   cfg_index,
    input  logic [WORD_WIDTH-1:0] cfg_data
);

    import rme_pkg::*;

    localparam int                    CNT_W    = $clog2(WORD_WIDTH);
    localparam logic [WORD_WIDTH-1:0] WORD_ONE = {{(WORD_WIDTH-1){1'b0}}, 1'b1};
    localparam logic [WORD_WIDTH-1:0] WORD_TWO = {{(WORD_WIDTH-2){1'b0}}, 2'b10};

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_SQUARE = 5'b00100,
        S_MULT   = 5'b01000,
        S_FLUSH  = 5'b10000
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [WORD_WIDTH-1:0] exponent_reg;
    logic [WORD_WIDTH-1:0] modulus_reg;
    logic [WORD_WIDTH-1:0] exp_sh_reg;
    logic [WORD_WIDTH-1:0] exp_sh_next;
    logic [CNT_W-1:0]      bit_cnt_reg;
    logic [CNT_W-1:0]      bit_cnt_next;
    logic [WORD_WIDTH-1:0] acc_reg;
    logic [WORD_WIDTH-1:0] acc_next;
    logic [WORD_WIDTH-1:0] base_reg;
    logic [WORD_WIDTH-1:0] base_next;
    logic                  start_reg;
    logic                  start_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [WORD_WIDTH-1:0] out_data_reg;
    logic [WORD_WIDTH-1:0] out_data_next;

    logic [WORD_WIDTH-1:0] mm_a;
    logic [WORD_WIDTH-1:0] mm_b;
    logic                  mm_done;
    logic [WORD_WIDTH-1:0] mm_product;
    logic                  in_fire;

    rme_modmul #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .a       (mm_a),
        .b       (mm_b),
        .m       (modulus_reg),
        .done    (mm_done),
        .product (mm_product)
    );

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == S_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign power_value = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= WORD_ONE;
            modulus_reg  <= WORD_TWO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_EXPONENT)
            begin
                exponent_reg <= cfg_data;
            end
            else if (cfg_index == REG_MODULUS)
            begin
                modulus_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        mm_a = acc_reg;
        mm_b = acc_reg;
        if (state_reg == S_REDUCE)
        begin
            mm_a = WORD_ONE;
            mm_b = base_reg;
        end
        else if (state_reg == S_MULT)
        begin
            mm_b = base_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        exp_sh_next    = exp_sh_reg;
        bit_cnt_next   = bit_cnt_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    base_next    = base_value;
                    exp_sh_next  = exponent_reg;
                    bit_cnt_next = CNT_W'(WORD_WIDTH - 1);
                    priority if (exponent_reg == '0)
                    begin
                        acc_next   = WORD_ONE;
                        state_next = S_FLUSH;
                    end
                    else if (modulus_reg[WORD_WIDTH-1:1] == '0)
                    begin
                        acc_next   = '0;
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        acc_next   = WORD_ONE;
                        start_next = 1'b1;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (mm_done)
                begin
                    base_next  = mm_product;
                    start_next = 1'b1;
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE, S_MULT:
            begin
                if (mm_done)
                begin
                    acc_next = mm_product;
                    if (state_reg == S_SQUARE && exp_sh_reg[WORD_WIDTH-1])
                    begin
                        start_next = 1'b1;
                        state_next = S_MULT;
                    end
                    else
                    begin
                        exp_sh_next = {exp_sh_reg[WORD_WIDTH-2:0], 1'b0};
                        if (bit_cnt_reg == '0)
                        begin
                            state_next = S_FLUSH;
                        end
                        else
                        begin
                            bit_cnt_next = bit_cnt_reg - 1'b1;
                            start_next   = 1'b1;
                            state_next   = S_SQUARE;
                        end
                    end
                end
            end
            S_FLUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = acc_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            bit_cnt_reg   <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_sh_reg   <= exp_sh_next;
        acc_reg      <= acc_next;
        base_reg     <= base_next;
        out_data_reg <= out_data_next;
    end

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_start_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> (state_reg == S_REDUCE || state_reg == S_SQUARE
                       || state_reg == S_MULT))
        else $error("multiplier started outside a multiply state");

    a_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
        mm_done |-> (state_reg == S_REDUCE || state_reg == S_SQUARE
                     || state_reg == S_MULT))
        else $error("multiplier finished outside a multiply state");

    a_result_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FLUSH && (!out_valid_reg || out_ready)) |=>
            (out_valid_reg && state_reg == S_IDLE))
        else $error("finished result not moved to output register");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input accepted while a transaction is in progress");

endmodule

### sim/rme_checker.sv
`timescale 1ns / 1ps
// Checker for the modular exponentiation block: watches the key, input and result channels,
// predicts each power from the current key and compares it with the returned value.
// Depends on rme_pkg for the register indexes.
module rme_checker #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [WORD_WIDTH-1:0] base_value,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [WORD_WIDTH-1:0] power_value,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  rme_pkg::cfg_index_t   cfg_index,
    input  logic [WORD_WIDTH-1:0] cfg_data,
    output int                    failures,
    output int                    pending
);

    typedef logic [WORD_WIDTH-1:0] word_t;

    localparam word_t EXPONENT_AT_RESET = 1;
    localparam word_t MODULUS_AT_RESET  = 2;

    word_t key_exponent = EXPONENT_AT_RESET;
    word_t key_modulus  = MODULUS_AT_RESET;
    word_t expected_powers[$];
    int    mismatch_count = 0;

    // right-to-left binary powering with double-width products
    function automatic word_t modular_power(input word_t base_in, input word_t exp_in,
                                            input word_t mod_in);
        logic [2*WORD_WIDTH-1:0] acc;
        logic [2*WORD_WIDTH-1:0] sq;
        word_t                   bits;
        if (exp_in == 0)
            return 1;
        if (mod_in <= 1)
            return 0;
        acc  = 1;
        sq   = (2*WORD_WIDTH)'(base_in % mod_in);
        bits = exp_in;
        while (bits != 0)
        begin
            if (bits[0])
                acc = (acc * sq) % mod_in;
            sq   = (sq * sq) % mod_in;
            bits = bits >> 1;
        end
        return acc[WORD_WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        word_t want;
        if (!rst_n)
        begin
            key_exponent = EXPONENT_AT_RESET;
            key_modulus  = MODULUS_AT_RESET;
            expected_powers.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_powers.size() == 0)
                    report_mismatch("result transaction with nothing outstanding", power_value,
                                    '0);
                else
                begin
                    want = expected_powers.pop_front();
                    if (power_value !== want)
                        report_mismatch("power_value", power_value, want);
                end
            end
            if (in_valid && in_ready)
                expected_powers.push_back(modular_power(base_value, key_exponent, key_modulus));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rme_pkg::REG_EXPONENT)
                    key_exponent = cfg_data;
                else if (cfg_index == rme_pkg::REG_MODULUS)
                    key_modulus = cfg_data;
            end
            pending  <= expected_powers.size();
            failures <= mismatch_count;
        end
    end

endmodule

### sim/rsa_modular_exponentiation_test.sv
`timescale 1ns / 1ps
// Top of the modular exponentiation testbench: clock, reset, key writes, base stimulus,
// result back-pressure, watchdog and verdict. Depends on rme_pkg, the block and rme_checker.
module rsa_modular_exponentiation_test;

    localparam int WORD_WIDTH      = 32;
    localparam int RANDOM_PHASES   = 16;
    localparam int BASES_PER_PHASE = 16;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 50;
    localparam int HOLD_AT_RESULT  = 40;
    localparam int HOLD_CYCLES     = 5000;
    localparam int CALM_FIRST      = 120;
    localparam int CALM_LAST       = 180;
    localparam int WATCHDOG_LIMIT  = 40000;

    typedef logic [WORD_WIDTH-1:0] word_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    word_t               base_value;
    logic                out_valid;
    logic                out_ready;
    word_t               power_value;
    logic                cfg_valid;
    logic                cfg_ready;
    rme_pkg::cfg_index_t cfg_index;
    word_t               cfg_data;

    int failures;
    int pending;
    int bases_sent    = 0;
    int keys_applied  = 0;
    int results_taken = 0;
    int idle_cycles   = 0;

    rsa_modular_exponentiation #(
        .WORD_WIDTH(WORD_WIDTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .base_value (base_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .power_value(power_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    rme_checker #(
        .WORD_WIDTH(WORD_WIDTH)
    ) power_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .base_value (base_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .power_value(power_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .failures   (failures),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic offer_base(input word_t value);
        int gap;
        gap = 0;
        if (!(bases_sent >= CALM_FIRST && bases_sent < CALM_LAST))
            while ($urandom_range(99) < 30)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        base_value <= value;
        do @(posedge clk); while (!in_ready);
        bases_sent++;
    endtask

    // drain outstanding results, then write both key registers back to back
    task automatic apply_key(input word_t exponent_value, input word_t modulus_value);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= rme_pkg::REG_EXPONENT;
        cfg_data  <= exponent_value;
        do @(posedge clk); while (!cfg_ready);
        cfg_index <= rme_pkg::REG_MODULUS;
        cfg_data  <= modulus_value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        keys_applied++;
    endtask

    initial
    begin
        word_t e;
        word_t m;
        word_t b;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        base_value = '0;
        cfg_valid  = 1'b0;
        cfg_index  = rme_pkg::REG_EXPONENT;
        cfg_data   = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key: exponent 1, modulus 2
        offer_base(0);
        offer_base(1);
        offer_base(32'hFFFF_FFFF);
        apply_key(0, 32'hFFFF_FFFF);
        offer_base(0);
        offer_base(32'hFFFF_FFFF);
        apply_key(5, 1);
        offer_base(7);
        apply_key(3, 0);
        offer_base(9);
        apply_key(17, 3233);
        offer_base(65);
        offer_base(0);
        offer_base(3233 + 65);
        apply_key(2753, 3233);
        offer_base(2790);
        apply_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_base(32'hFFFF_FFFE);
        offer_base(2);
        offer_base(32'hFFFF_FFFF);
        apply_key(32'hFFFF_FFFF, 32'hFFFF_FFFB);
        offer_base($urandom);
        offer_base($urandom);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case ($urandom_range(9))
                0:       e = 0;
                1:       e = $urandom_range(16, 1);
                2:       e = 65537;
                3:       e = 32'hFFFF_FFFF;
                default: e = $urandom;
            endcase
            case ($urandom_range(19))
                0:       m = 0;
                1:       m = 1;
                2, 3:    m = 2;
                4, 5, 6: m = $urandom_range(65535, 3);
                7, 8:    m = 32'hFFFF_FFFF;
                default: m = $urandom;
            endcase
            apply_key(e, m);
            for (int i = 0; i < BASES_PER_PHASE; i++)
            begin
                case ($urandom_range(9))
                    0:       b = 0;
                    1:       b = 1;
                    2:       b = m - 1;
                    3:       b = m;
                    4:       b = $urandom_range(255);
                    default: b = $urandom;
                endcase
                offer_base(b);
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Raised %0d base values under %0d keys, reset key included.",
                 bases_sent, keys_applied + 1);
        $display("Compared %0d power results, including one long receiver stall.",
                 results_taken);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: random back-pressure, one long hold-off, one stretch always ready
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_taken++;
                if (results_taken == HOLD_AT_RESULT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= (results_taken >= CALM_FIRST && results_taken < CALM_LAST)
                             || ($urandom_range(99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: %0d cycles without a transaction", $time, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule

### sim.f
rtl/rme_pkg.sv
rtl/rme_modmul.sv
rtl/rsa_modular_exponentiation.sv
sim/rme_checker.sv
sim/rsa_modular_exponentiation_test.sv
